// File: src/sra_pkg.sv
// Shared constants, types and helper functions for the radix-to-ASCII converter.
`timescale 1ns / 1ps

package sra_pkg;

    // Data path sizes
    localparam int VALUE_WIDTH = 32;
    localparam int MAX_DIGITS  = 32;
    localparam int IDX_W       = $clog2(MAX_DIGITS);
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int STEP_W      = $clog2(VALUE_WIDTH);
    localparam int RADIX_W     = 6;
    localparam int REM_W       = RADIX_W;
    localparam int CHAR_W      = 7;
    localparam int TDATA_IN_W  = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int TDATA_OUT_W = ((CHAR_W + 7) / 8) * 8;

    // Radix limits and reset value
    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(36);

    // Character codes
    localparam logic [CHAR_W-1:0] MINUS_CODE  = CHAR_W'(45);
    localparam logic [CHAR_W-1:0] ZERO_CODE   = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] LOWER_A     = CHAR_W'(97);
    localparam logic [CHAR_W-1:0] LOWER_Z     = CHAR_W'(122);
    localparam logic [REM_W-1:0]  DIGIT_TEN   = REM_W'(10);
    localparam logic [REM_W-1:0]  DIGIT_LIMIT = REM_W'(35);

    // Result of one division pass
    typedef struct packed {
        logic                   done;
        logic [VALUE_WIDTH-1:0] quotient;
        logic [REM_W-1:0]       remainder;
    } div_result_t;

    // Clamp the radix register to the usable range
    function automatic logic [RADIX_W-1:0] effective_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

    // Map a digit value to its ASCII glyph
    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [REM_W-1:0] d);
        logic [CHAR_W-1:0] code;
        if (d < DIGIT_TEN) begin
            code = ZERO_CODE + CHAR_W'(d);
        end else if (d <= DIGIT_LIMIT) begin
            code = LOWER_A + CHAR_W'(d - DIGIT_TEN);
        end else begin
            code = LOWER_Z;
        end
        return code;
    endfunction

endpackage

// File: src/sra_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module sra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/sra_divider.sv
// Restoring divider: magnitude by radix, one quotient bit per cycle.
`timescale 1ns / 1ps

module sra_divider (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [sra_pkg::VALUE_WIDTH-1:0] dividend,
    input  logic [sra_pkg::RADIX_W-1:0]     divisor,
    output sra_pkg::div_result_t            result
);

    logic                            busy_reg,  busy_next;
    logic                            done_reg,  done_next;
    logic [sra_pkg::STEP_W-1:0]      step_reg,  step_next;
    logic [sra_pkg::VALUE_WIDTH-1:0] quot_reg,  quot_next;
    logic [sra_pkg::REM_W-1:0]       rem_reg,   rem_next;

    logic [sra_pkg::REM_W:0] trial;
    logic [sra_pkg::REM_W:0] diff;
    logic                    fits;

    // Shift the next dividend bit into the partial remainder and try a subtract
    assign trial = {rem_reg, quot_reg[sra_pkg::VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            quot_next = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            quot_next = {quot_reg[sra_pkg::VALUE_WIDTH-2:0], fits};
            rem_next  = fits ? diff[sra_pkg::REM_W-1:0] : trial[sra_pkg::REM_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == sra_pkg::STEP_W'(sra_pkg::VALUE_WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state; payload needs no reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign result.done      = done_reg;
    assign result.quotient  = quot_reg;
    assign result.remainder = rem_reg;

endmodule

// File: src/signed_radix_to_ascii.sv
// Top level: signed integer to ASCII text in radix 2 to 36.
`timescale 1ns / 1ps

// Converts one signed 32-bit integer per input beat into ASCII characters, one
// character per output beat: a '-' for negative values, then the digits of the
// magnitude most significant first ('0'-'9', then 'a'-'z'); m_tlast marks the
// final character, and zero gives a single '0'. The radix comes from cfg_wr_data
// (values below 2 act as 2, above 36 as 36; reset value 36) and may only be
// written while the block is idle. One item is processed at a time: s_tready is
// low from acceptance until the last character is taken. Each digit costs one
// pass of the shared bit-serial divider: a start state, then all 32 quotient
// bits, then a done flag. Each output character then passes through a read, a
// load and a send state, the send waiting on any stall on m_tready; the sign
// has a state of its own. A value has at most six digits in radix 36 and 32
// digits for the most negative value in radix 2.
module signed_radix_to_ascii (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [sra_pkg::RADIX_W-1:0]     cfg_wr_data,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sra_pkg::TDATA_IN_W-1:0]  s_tdata,   // [31:0] number_in
    // output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sra_pkg::TDATA_OUT_W-1:0] m_tdata,   // [6:0] char_code, [7] zero
    output logic                            m_tlast    // last_char
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_SIGN,
        ST_READ,
        ST_LOAD,
        ST_SEND
    } state_t;

    state_t                          state_reg,     state_next;
    logic [sra_pkg::RADIX_W-1:0]     radix_reg,     radix_next;
    logic                            neg_reg,       neg_next;
    logic [sra_pkg::VALUE_WIDTH-1:0] mag_reg,       mag_next;
    logic [sra_pkg::CNT_W-1:0]       count_reg,     count_next;
    logic [sra_pkg::CNT_W-1:0]       idx_reg,       idx_next;
    logic                            out_valid_reg, out_valid_next;
    logic [sra_pkg::CHAR_W-1:0]      out_char_reg,  out_char_next;
    logic                            out_last_reg,  out_last_next;

    logic [sra_pkg::VALUE_WIDTH-1:0] number_in;
    logic [sra_pkg::CNT_W-1:0]       count_inc;
    logic [sra_pkg::CNT_W-1:0]       idx_dec;
    logic                            div_start;
    sra_pkg::div_result_t            div_res;

    logic                            ram_wr_en;
    logic                            ram_rd_en;
    logic [sra_pkg::REM_W-1:0]       ram_rd_data;

    assign number_in = s_tdata[sra_pkg::VALUE_WIDTH-1:0];
    assign count_inc = count_reg + 1'b1;
    assign idx_dec   = idx_reg - 1'b1;
    assign div_start = (state_reg == ST_START);
    assign ram_wr_en = (state_reg == ST_WAIT) && div_res.done;
    assign ram_rd_en = (state_reg == ST_READ);

    // Shared divider: one digit per pass
    sra_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mag_reg),
        .divisor  (sra_pkg::effective_radix(radix_reg)),
        .result   (div_res)
    );

    // Digit store, least significant digit at address zero
    sra_ram #(
        .WIDTH (sra_pkg::REM_W),
        .DEPTH (sra_pkg::MAX_DIGITS)
    ) u_digits (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (count_reg[sra_pkg::IDX_W-1:0]),
        .wr_data (div_res.remainder),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_dec[sra_pkg::IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    // Sequencer: divide out digits, then emit sign and digits
    always_comb begin
        state_next     = state_reg;
        radix_next     = radix_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        if (cfg_wr_en) begin
            radix_next = cfg_wr_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    neg_next   = number_in[sra_pkg::VALUE_WIDTH-1];
                    mag_next   = number_in[sra_pkg::VALUE_WIDTH-1] ? (~number_in + 1'b1)
                                                                   : number_in;
                    count_next = '0;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (div_res.done) begin
                    count_next = count_inc;
                    mag_next   = div_res.quotient;
                    idx_next   = count_inc;
                    if ((div_res.quotient != '0) &&
                        (count_inc < sra_pkg::CNT_W'(sra_pkg::MAX_DIGITS))) begin
                        state_next = ST_START;
                    end else if (neg_reg) begin
                        out_valid_next = 1'b1;
                        out_char_next  = sra_pkg::MINUS_CODE;
                        out_last_next  = 1'b0;
                        state_next     = ST_SIGN;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_SIGN: begin
                if (m_tready) begin
                    out_valid_next = 1'b0;
                    state_next     = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                out_valid_next = 1'b1;
                out_char_next  = sra_pkg::digit_glyph(ram_rd_data);
                out_last_next  = (idx_reg == sra_pkg::CNT_W'(1));
                state_next     = ST_SEND;
            end
            ST_SEND: begin
                if (m_tready) begin
                    out_valid_next = 1'b0;
                    if (out_last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_dec;
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            radix_reg     <= sra_pkg::RADIX_RESET;
            neg_reg       <= 1'b0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            radix_reg     <= radix_next;
            neg_reg       <= neg_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
        mag_reg      <= mag_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = sra_pkg::TDATA_OUT_W'(out_char_reg);
    assign m_tlast  = out_last_reg;

endmodule

// File: src/sra_checker.sv
// Port-level checker for the radix-to-ASCII converter, bound to the top level.
`timescale 1ns / 1ps

module sra_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [sra_pkg::TDATA_OUT_W-1:0] m_tdata,
    input logic                            m_tlast
);

    // Never take a new item while a character is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while output beat pending");

    // Drop ready right after an item is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready stayed high after accepting an item");

    // The final character ends the item's output
    a_gap_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
        else $error("output continued after last character");

    // Hold a stalled beat
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled output beat changed");

    // Characters are 7-bit ASCII
    a_ascii_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[sra_pkg::TDATA_OUT_W-1:sra_pkg::CHAR_W] == '0))
        else $error("character code outside 7-bit range");

endmodule

bind signed_radix_to_ascii sra_checker u_sra_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
